[hdl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// Types and constants shared by the delimited field splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  // widths of the item fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned FCNT_W   = 5;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned STATUS_W = 2;

  // most results one record can produce
  localparam int unsigned RESULT_CAP = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 2'd3;

  // reset values of the registers
  localparam logic [BYTE_W-1:0] SEPARATOR_RST   = 8'd44;
  localparam logic [FCNT_W-1:0] FIELD_COUNT_RST = 5'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COUNT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] separator;
    logic              merge_mode;
    logic              take_mode;
    logic [FCNT_W-1:0] field_count;
  } cfg_t;

  // one entry of the field table
  typedef struct packed {
    logic [OFFS_W-1:0] fstart;
    logic [OFFS_W-1:0] fend;
  } field_t;

  // table write request from the scanner
  typedef struct packed {
    logic              en;
    logic [FCNT_W-1:0] idx;
    field_t            entry;
  } wr_req_t;

  // summary of a record, valid with its last byte
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FCNT_W-1:0]   count;
    field_t              final_field;
  } rec_info_t;

endpackage

`default_nettype wire

[hdl/dfs_in_if.sv]
// ----------------------------------------------------------------------------
// dfs_in_if
// Byte channel into the splitter: one record byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/dfs_out_if.sv]
// ----------------------------------------------------------------------------
// dfs_out_if
// Result channel out of the splitter: one field or one error per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_index;
  logic [15:0] start_offs;
  logic [15:0] end_offs;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output field_index, output start_offs,
                  output end_offs, output status, output last_result, input ready);
  modport sink   (input valid, input field_index, input start_offs,
                  input end_offs, input status, input last_result, output ready);
endinterface

`default_nettype wire

[hdl/delimited_field_splitter_unit.sv]
// ----------------------------------------------------------------------------
// delimited_field_splitter_unit
// Splits a byte record into a configured number of fields at a separator
// byte and reports each field's start and end offsets.
//
// Usage:
//   in_i   carries one record byte per item with a last_byte flag. While a
//          record is streaming, one byte is taken every cycle.
//   out_o  gives field_count results in field order after the last byte, or
//          a single error result (status 1 wrong count, 2 too long).
//   cfg    plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); write only
//          between records, once all results have been taken.
// Timing: after the last byte the input is held off until every result, or the
//   error result, has been issued; the single read port of the field table gives
//   one entry per cycle while the read stage is not stalled. The first result
//   passes the sequencer state, the table read stage and the output register;
//   results then follow one per cycle while the receiver takes them.
// Stalls: a stalled receiver holds the output register and the table read
//   stage; results queue there, and the next record may start once all are issued.
// Reset: configuration registers return to their reset values, the scanner starts inside
//   field 0; the field table needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_field_splitter_unit #(
  parameter int unsigned MAX_FIELDS = 16,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  dfs_in_if.sink                                in_i,
  dfs_out_if.source                             out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned FIELD_LIMIT = (MAX_FIELDS < dfs_pkg::RESULT_CAP) ?
                                        MAX_FIELDS : dfs_pkg::RESULT_CAP;
  localparam int unsigned AW = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

  typedef enum logic [2:0] {
    ST_SCAN = 3'b001,
    ST_EMIT = 3'b010,
    ST_ERR  = 3'b100
  } state_e;

  state_e state_q, state_d;

  dfs_pkg::cfg_t      cfg_q;
  dfs_pkg::wr_req_t   wr_req;
  dfs_pkg::rec_info_t rec_info;
  dfs_pkg::field_t    rd_data;

  logic in_fire;
  logic issue;
  logic iss_last;
  logic load;

  // latched record summary
  logic [1:0]  rec_status_q;
  logic [4:0]  rec_count_q;
  logic [15:0] rec_start_q;
  logic [15:0] rec_end_q;
  logic [4:0]  iss_q;

  // table read stage
  logic        rd_v_q;
  logic [3:0]  rd_idx_q;
  logic        rd_last_q;
  logic        rd_fin_q;
  logic [1:0]  rd_status_q;
  logic [15:0] rd_fs_q;
  logic [15:0] rd_fe_q;

  // output register
  logic        out_v_q;
  logic [3:0]  out_idx_q;
  logic [15:0] out_fs_q;
  logic [15:0] out_fe_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.separator   <= dfs_pkg::SEPARATOR_RST;
      cfg_q.merge_mode  <= 1'b0;
      cfg_q.take_mode   <= 1'b0;
      cfg_q.field_count <= dfs_pkg::FIELD_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dfs_pkg::REG_SEPARATOR:   cfg_q.separator   <= cfg_wdata_i;
        dfs_pkg::REG_MERGE_MODE:  cfg_q.merge_mode  <= cfg_wdata_i[0];
        dfs_pkg::REG_TAKE_MODE:   cfg_q.take_mode   <= cfg_wdata_i[0];
        dfs_pkg::REG_FIELD_COUNT: cfg_q.field_count <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_SCAN);
  assign in_fire    = in_i.valid && in_i.ready;

  dfs_scanner #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (in_fire),
    .byte_i (in_i.byte_in),
    .last_i (in_i.last_byte),
    .wr_o   (wr_req),
    .rec_o  (rec_info)
  );

  dfs_field_mem #(
    .DEPTH (FIELD_LIMIT),
    .AW    (AW)
  ) u_field_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && wr_req.en),
    .wr_addr_i (wr_req.idx[AW-1:0]),
    .wr_data_i (wr_req.entry),
    .rd_en_i   (issue),
    .rd_addr_i (iss_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // result sequencing
  assign load     = rd_v_q && (!out_v_q || out_o.ready);
  assign issue    = ((state_q == ST_EMIT) || (state_q == ST_ERR)) && (!rd_v_q || load);
  assign iss_last = ((iss_q + 5'd1) == rec_count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SCAN: begin
        if (in_fire && in_i.last_byte) begin
          state_d = (rec_info.status == dfs_pkg::STATUS_OK) ? ST_EMIT : ST_ERR;
        end
      end
      ST_EMIT: begin
        if (issue && iss_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_ERR: begin
        if (issue) begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
      iss_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire && in_i.last_byte) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + 5'd1;
      end
    end
  end

  // record summary, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_byte) begin
      rec_status_q <= rec_info.status;
      rec_count_q  <= rec_info.count;
      rec_start_q  <= rec_info.final_field.fstart;
      rec_end_q    <= rec_info.final_field.fend;
    end
  end

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (issue) begin
      rd_v_q <= 1'b1;
    end else if (load) begin
      rd_v_q <= 1'b0;
    end
  end

  // read stage payload; the final field and errors bypass the table
  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (state_q == ST_ERR) begin
        rd_idx_q    <= '0;
        rd_last_q   <= 1'b1;
        rd_fin_q    <= 1'b1;
        rd_status_q <= rec_status_q;
        rd_fs_q     <= '0;
        rd_fe_q     <= '0;
      end else begin
        rd_idx_q    <= iss_q[3:0];
        rd_last_q   <= iss_last;
        rd_fin_q    <= iss_last;
        rd_status_q <= dfs_pkg::STATUS_OK;
        rd_fs_q     <= rec_start_q;
        rd_fe_q     <= rec_end_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q    <= rd_idx_q;
      out_fs_q     <= rd_fin_q ? rd_fs_q : rd_data.fstart;
      out_fe_q     <= rd_fin_q ? rd_fe_q : rd_data.fend;
      out_status_q <= rd_status_q;
      out_last_q   <= rd_last_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.field_index = out_idx_q;
  assign out_o.start_offs  = out_fs_q;
  assign out_o.end_offs    = out_fe_q;
  assign out_o.status      = out_status_q;
  assign out_o.last_result = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // a finished record always leaves the scan state
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_byte) |=> (state_q != ST_SCAN))
    else $error("record end did not start result output");

  // reads stay inside the record's field count
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (state_q == ST_EMIT)) |-> (iss_q < rec_count_q))
    else $error("table read beyond field count");

  // a waiting read stage is never overwritten
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q && !load) |-> !issue)
    else $error("read stage overwritten while stalled");

endmodule

`default_nettype wire

[hdl/dfs_field_mem.sv]
// ----------------------------------------------------------------------------
// dfs_field_mem
// Field table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_field_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire dfs_pkg::field_t wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output      dfs_pkg::field_t rd_data_o
);

  dfs_pkg::field_t mem_q [DEPTH];
  dfs_pkg::field_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[hdl/dfs_scanner.sv]
// ----------------------------------------------------------------------------
// dfs_scanner
// Per-byte field scanner: tracks field/separator state, offsets and errors,
// issues field table writes and summarises the record on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_scanner #(
  parameter int unsigned FIELD_LIMIT = 16,
  parameter int unsigned MAX_LENGTH  = 65535
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dfs_pkg::cfg_t      cfg_i,
  input  wire logic               fire_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output      dfs_pkg::wr_req_t   wr_o,
  output      dfs_pkg::rec_info_t rec_o
);

  logic        in_sep_q, in_sep_d;
  logic [4:0]  cur_q, cur_d;
  logic [15:0] start_q, start_d;
  logic [15:0] pos_q, pos_d;
  logic        take_rest_q, take_rest_d;
  logic        cnt_err_q, cnt_err_d;
  logic        len_err_q, len_err_d;

  logic [4:0]  n;
  logic [4:0]  cur_inc;
  logic [4:0]  cur_inc2;
  logic        cnt_ok;
  logic        is_sep;
  logic        fin_sep;
  logic [4:0]  fin_cur;
  logic [4:0]  fin_inc;
  logic [15:0] fin_start;

  assign n        = cfg_i.field_count;
  assign cur_inc  = cur_q + 5'd1;
  assign cur_inc2 = cur_q + 5'd2;
  assign cnt_ok   = (n != 5'd0) && (n <= 5'(FIELD_LIMIT));
  assign is_sep   = (byte_i == cfg_i.separator);

  // byte scan
  always_comb begin
    in_sep_d    = in_sep_q;
    cur_d       = cur_q;
    start_d     = start_q;
    pos_d       = pos_q;
    take_rest_d = take_rest_q;
    cnt_err_d   = cnt_err_q;
    len_err_d   = len_err_q;
    wr_o        = '0;
    wr_o.idx    = cur_q;
    wr_o.entry  = '{fstart: start_q, fend: pos_q};
    if (pos_q >= 16'(MAX_LENGTH)) begin
      len_err_d = 1'b1;
    end else begin
      if (cnt_ok && !cnt_err_q && !take_rest_q) begin
        if (!in_sep_q) begin
          if (cfg_i.take_mode && (cur_inc >= n)) begin
            take_rest_d = 1'b1;
          end else if (is_sep) begin
            wr_o.en  = 1'b1;
            in_sep_d = 1'b1;
          end
        end else if (is_sep) begin
          if (!cfg_i.merge_mode) begin
            cur_d    = cur_inc;
            start_d  = pos_q;
            in_sep_d = 1'b0;
            if (cur_inc >= n) begin
              cnt_err_d = 1'b1;
            end else if (cfg_i.take_mode && (cur_inc2 >= n)) begin
              take_rest_d = 1'b1;
            end else begin
              wr_o.en    = 1'b1;
              wr_o.idx   = cur_inc;
              wr_o.entry = '{fstart: pos_q, fend: pos_q};
              in_sep_d   = 1'b1;
            end
          end
        end else begin
          cur_d    = cur_inc;
          start_d  = pos_q;
          in_sep_d = 1'b0;
          if (cur_inc >= n) begin
            cnt_err_d = 1'b1;
          end
        end
      end
      pos_d = pos_q + 16'd1;
    end
  end

  // record summary, taken on the last byte
  always_comb begin
    fin_sep   = in_sep_d;
    fin_cur   = cur_d;
    fin_start = start_d;
    if (!take_rest_d && in_sep_d && ((cur_d + 5'd1) < n)) begin
      fin_sep   = 1'b0;
      fin_cur   = cur_d + 5'd1;
      fin_start = pos_d;
    end
    fin_inc = fin_cur + 5'd1;
    rec_o.count             = n;
    rec_o.final_field       = '{fstart: fin_start, fend: pos_d};
    if (len_err_d) begin
      rec_o.status = dfs_pkg::STATUS_LENGTH;
    end else if (!cnt_ok || cnt_err_d) begin
      rec_o.status = dfs_pkg::STATUS_COUNT;
    end else if (fin_sep || (fin_inc != n)) begin
      rec_o.status = dfs_pkg::STATUS_COUNT;
    end else begin
      rec_o.status = dfs_pkg::STATUS_OK;
    end
  end

  // scan state, cleared at the end of each record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sep_q    <= 1'b0;
      cur_q       <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      take_rest_q <= 1'b0;
      cnt_err_q   <= 1'b0;
      len_err_q   <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        in_sep_q    <= 1'b0;
        cur_q       <= '0;
        start_q     <= '0;
        pos_q       <= '0;
        take_rest_q <= 1'b0;
        cnt_err_q   <= 1'b0;
        len_err_q   <= 1'b0;
      end else begin
        in_sep_q    <= in_sep_d;
        cur_q       <= cur_d;
        start_q     <= start_d;
        pos_q       <= pos_d;
        take_rest_q <= take_rest_d;
        cnt_err_q   <= cnt_err_d;
        len_err_q   <= len_err_d;
      end
    end
  end

  // a table write stays below the configured field count
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && wr_o.en) |-> (wr_o.idx < n))
    else $error("field table write beyond field count");

  // the position never passes the length limit
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 16'(MAX_LENGTH))
    else $error("position beyond length limit");

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delimited field splitter. A short table of
// records covers the corner cases of the scanner, then random records under
// random settings run through three idling phases, two with a long receiver
// hold-off. Every result is compared field by field with a local prediction
// of the field table or with a result given outright in the directed table.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_FIELDS   = 16;
  localparam int unsigned MAX_LENGTH   = 65535;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned SETTLE_GAP   = 8;
  localparam int unsigned TAIL_GAP     = 40;
  localparam int unsigned HOLD_LEN     = 250;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam logic [dfs_pkg::BYTE_W-1:0] COMMA = 8'h2C;

  // one field report, or one error report
  typedef struct packed {
    logic [dfs_pkg::FIDX_W-1:0]   fidx;
    logic [dfs_pkg::OFFS_W-1:0]   fstart;
    logic [dfs_pkg::OFFS_W-1:0]   fend;
    logic [dfs_pkg::STATUS_W-1:0] status;
    logic                         fin;
  } field_res_t;

  // one row of the directed table: a register write or a record byte
  typedef struct packed {
    logic                           wr;
    logic [dfs_pkg::CFG_IDX_W-1:0]  ridx;
    logic [dfs_pkg::CFG_DATA_W-1:0] rval;
    logic [dfs_pkg::BYTE_W-1:0]     ch;
    logic                           fin;
    logic                           typed;
    field_res_t                     want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  dfs_in_if  in_ch ();
  dfs_out_if out_ch ();

  delimited_field_splitter_unit #(
    .MAX_FIELDS (MAX_FIELDS),
    .MAX_LENGTH (MAX_LENGTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // predicted settings
  logic [dfs_pkg::BYTE_W-1:0] p_sep   = dfs_pkg::SEPARATOR_RST;
  logic                       p_merge = 1'b0;
  logic                       p_take  = 1'b0;
  logic [dfs_pkg::FCNT_W-1:0] p_count = dfs_pkg::FIELD_COUNT_RST;

  // predicted scanner state and field table
  bit                         in_gap;
  int unsigned                fld;
  int unsigned                fld_start;
  int unsigned                pos;
  bit                         rest_mode;
  bit                         too_many;
  bit                         too_long;
  logic [dfs_pkg::OFFS_W-1:0] start_tab [MAX_FIELDS];
  logic [dfs_pkg::OFFS_W-1:0] end_tab   [MAX_FIELDS];

  field_res_t burst [$];
  field_res_t pending_fields [$];

  int  errors      = 0;
  int  tx_idle_pct = 19;
  int  rx_idle_pct = 83;
  int  hold_seq    = 0;
  int  hold_seen   = 0;
  int  hold_left   = 0;
  int  quiet       = 0;
  bit  streaming   = 1'b0;

  function automatic void clear_record();
    in_gap    = 1'b0;
    fld       = 0;
    fld_start = 0;
    pos       = 0;
    rest_mode = 1'b0;
    too_many  = 1'b0;
    too_long  = 1'b0;
  endfunction

  function automatic void keep_field(int unsigned idx, int unsigned s, int unsigned e);
    if (idx < MAX_FIELDS) begin
      start_tab[idx] = s[dfs_pkg::OFFS_W-1:0];
      end_tab[idx]   = e[dfs_pkg::OFFS_W-1:0];
    end
  endfunction

  // two-state scanner: inside a field, or just past a separator
  function automatic void scan_char(logic [dfs_pkg::BYTE_W-1:0] c);
    int unsigned n = p_count;
    if (!in_gap && p_take && fld + 1 >= n) begin
      rest_mode = 1'b1;
      return;
    end
    if (!in_gap) begin
      if (c == p_sep) begin
        keep_field(fld, fld_start, pos);
        in_gap = 1'b1;
      end
      return;
    end
    if (c == p_sep) begin
      if (p_merge) return;
      // second separator in a row: an empty field at its own offset
      fld++;
      fld_start = pos;
      in_gap    = 1'b0;
      if (fld >= n) too_many = 1'b1;
      else if (p_take && fld + 1 >= n) rest_mode = 1'b1;
      else begin
        keep_field(fld, pos, pos);
        in_gap = 1'b1;
      end
      return;
    end
    fld++;
    fld_start = pos;
    in_gap    = 1'b0;
    if (fld >= n) too_many = 1'b1;
  endfunction

  // predicts the results caused by one byte into burst
  function automatic void split_byte(logic [dfs_pkg::BYTE_W-1:0] c, bit fin);
    int unsigned                  n        = p_count;
    bit                           count_ok = (p_count >= 1) && (p_count <= MAX_FIELDS);
    logic [dfs_pkg::STATUS_W-1:0] st       = dfs_pkg::STATUS_OK;
    burst.delete();
    if (pos >= MAX_LENGTH) too_long = 1'b1;
    else begin
      if (count_ok && !too_many && !rest_mode) scan_char(c);
      pos++;
    end
    if (!fin) return;
    if (too_long) st = dfs_pkg::STATUS_LENGTH;
    else if (!count_ok || too_many) st = dfs_pkg::STATUS_COUNT;
    else begin
      // trailing separator leaves an empty final field
      if (!rest_mode && in_gap && fld + 1 < n) begin
        in_gap    = 1'b0;
        fld++;
        fld_start = pos;
      end
      if (in_gap || fld + 1 != n) st = dfs_pkg::STATUS_COUNT;
    end
    if (st != dfs_pkg::STATUS_OK) begin
      burst.push_back('{fidx: '0, fstart: '0, fend: '0, status: st, fin: 1'b1});
    end else begin
      keep_field(fld, fld_start, pos);
      for (int unsigned i = 0; i < n; i++) begin
        burst.push_back('{fidx: i[dfs_pkg::FIDX_W-1:0], fstart: start_tab[i],
                          fend: end_tab[i], status: dfs_pkg::STATUS_OK,
                          fin: (i + 1 == n)});
      end
    end
    clear_record();
  endfunction

  function automatic logic [dfs_pkg::BYTE_W-1:0] text_byte();
    logic [dfs_pkg::BYTE_W-1:0] b;
    b = 8'($urandom_range(255));
    if (b == p_sep) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic plan_row_t cfg_row(logic [dfs_pkg::CFG_IDX_W-1:0] idx,
                                        logic [dfs_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r = '0;
    r.wr   = 1'b1;
    r.ridx = idx;
    r.rval = val;
    return r;
  endfunction

  function automatic plan_row_t byte_row(logic [dfs_pkg::BYTE_W-1:0] ch, bit fin = 1'b0);
    plan_row_t r = '0;
    r.ch  = ch;
    r.fin = fin;
    return r;
  endfunction

  // last byte of a record whose single result is known outright
  function automatic plan_row_t typed_row(logic [dfs_pkg::BYTE_W-1:0] ch, int unsigned fs,
                                          int unsigned fe,
                                          logic [dfs_pkg::STATUS_W-1:0] st);
    plan_row_t r = '0;
    r.ch    = ch;
    r.fin   = 1'b1;
    r.typed = 1'b1;
    r.want  = '{fidx: '0, fstart: fs[dfs_pkg::OFFS_W-1:0], fend: fe[dfs_pkg::OFFS_W-1:0],
                status: st, fin: 1'b1};
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // offer one byte, wait for it to be taken, then predict its results
  task automatic send_byte(logic [dfs_pkg::BYTE_W-1:0] c, bit fin, bit typed,
                           field_res_t want);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= c;
    in_ch.last_byte <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    streaming = 1'b1;
    split_byte(c, fin);
    if (typed) pending_fields.push_back(want);
    else foreach (burst[k]) pending_fields.push_back(burst[k]);
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    if (streaming) begin
      in_ch.valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clk_i);
      repeat (SETTLE_GAP) @(posedge clk_i);
      streaming = 1'b0;
    end
  endtask

  task automatic program_reg(logic [dfs_pkg::CFG_IDX_W-1:0] idx,
                             logic [dfs_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      dfs_pkg::REG_SEPARATOR:   p_sep   = val;
      dfs_pkg::REG_MERGE_MODE:  p_merge = val[0];
      dfs_pkg::REG_TAKE_MODE:   p_take  = val[0];
      dfs_pkg::REG_FIELD_COUNT: p_count = val[dfs_pkg::FCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_result();
    field_res_t want;
    if (pending_fields.size() == 0) begin
      flag_mismatch($sformatf("unexpected result: index %0d status %0d",
                              out_ch.field_index, out_ch.status));
      return;
    end
    want = pending_fields.pop_front();
    if (out_ch.field_index !== want.fidx)
      flag_mismatch($sformatf("field_index %0d, want %0d", out_ch.field_index, want.fidx));
    if (out_ch.start_offs !== want.fstart)
      flag_mismatch($sformatf("start_offs %0d, want %0d", out_ch.start_offs, want.fstart));
    if (out_ch.end_offs !== want.fend)
      flag_mismatch($sformatf("end_offs %0d, want %0d", out_ch.end_offs, want.fend));
    if (out_ch.status !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
    if (out_ch.last_result !== want.fin)
      flag_mismatch($sformatf("last_result %0b, want %0b", out_ch.last_result, want.fin));
  endtask

  // result side: check taken items, stall at random or for a long hold-off
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) check_result();
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles in which nothing moves
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
    begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t                      plan [$];
    logic [dfs_pkg::BYTE_W-1:0]     rec [$];
    logic [dfs_pkg::CFG_DATA_W-1:0] v;
    int unsigned                    nf;
    int unsigned                    flen;
    int unsigned                    sent;
    int unsigned                    hold_grace;

    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.byte_in   = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    clear_record();

    // reset setting: one field, comma separator
    plan.push_back(typed_row(8'h00, 0, 1, dfs_pkg::STATUS_OK));
    // leading separator closes field 0 and leaves the scanner past it
    plan.push_back(typed_row(COMMA, 0, 0, dfs_pkg::STATUS_COUNT));
    // leading then adjacent separators: two empty fields
    plan.push_back(cfg_row(dfs_pkg::REG_FIELD_COUNT, 3));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row(8'hFF, 1'b1));
    // trailing separator: empty final field
    plan.push_back(byte_row("a"));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row("b"));
    plan.push_back(byte_row(COMMA, 1'b1));
    // merge: a run of separators acts as one, a leading one still counts
    plan.push_back(cfg_row(dfs_pkg::REG_MERGE_MODE, 1));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row("a"));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row("b", 1'b1));
    // take: final field opened by a second separator starts at it
    plan.push_back(cfg_row(dfs_pkg::REG_MERGE_MODE, 0));
    plan.push_back(cfg_row(dfs_pkg::REG_TAKE_MODE, 1));
    plan.push_back(byte_row("a"));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row("b"));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row("c", 1'b1));
    // too many fields
    plan.push_back(cfg_row(dfs_pkg::REG_TAKE_MODE, 0));
    plan.push_back(cfg_row(dfs_pkg::REG_FIELD_COUNT, 2));
    plan.push_back(byte_row(COMMA));
    plan.push_back(byte_row(COMMA));
    plan.push_back(typed_row(COMMA, 0, 0, dfs_pkg::STATUS_COUNT));
    // field count of zero is never valid
    plan.push_back(cfg_row(dfs_pkg::REG_SEPARATOR, 8'hFF));
    plan.push_back(cfg_row(dfs_pkg::REG_FIELD_COUNT, 0));
    plan.push_back(typed_row("q", 0, 0, dfs_pkg::STATUS_COUNT));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[r]) begin
      if (plan[r].wr) begin
        settle();
        program_reg(plan[r].ridx, plan[r].rval);
      end else begin
        send_byte(plan[r].ch, plan[r].fin, plan[r].typed, plan[r].want);
      end
    end

    // random records in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct <= (ph == 0) ? 19 : (ph == 1) ? 83 : 0;
      rx_idle_pct <= (ph == 0) ? 83 : (ph == 1) ? 19 : 0;
      hold_grace = 0;
      if (ph != 1) begin
        // long receiver hold-off while records keep coming
        hold_seq   <= hold_seq + 1;
        hold_grace = 5;
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        if (hold_grace > 0) hold_grace--;
        else if ($urandom_range(2) == 0) begin
          settle();
          case ($urandom_range(3))
            0:       v = COMMA;
            1:       v = 8'h00;
            2:       v = 8'hFF;
            default: v = 8'($urandom_range(255));
          endcase
          program_reg(dfs_pkg::REG_SEPARATOR, v);
          program_reg(dfs_pkg::REG_MERGE_MODE, 8'($urandom_range(1)));
          program_reg(dfs_pkg::REG_TAKE_MODE, 8'($urandom_range(1)));
          case ($urandom_range(15))
            0:       v = $urandom_range(1) ? 8'd0 : 8'($urandom_range(31, 17));
            1, 2, 3: v = 8'd1;
            4, 5, 6: v = 8'd16;
            default: v = 8'($urandom_range(16, 1));
          endcase
          program_reg(dfs_pkg::REG_FIELD_COUNT, v);
        end
        rec.delete();
        if ($urandom_range(9) < 8) begin
          // well-formed record, sometimes one field off
          nf = (p_count >= 1 && p_count <= MAX_FIELDS) ? p_count : $urandom_range(3, 1);
          if ($urandom_range(7) == 0) nf = nf + 1;
          else if ($urandom_range(7) == 0 && nf > 1) nf = nf - 1;
          for (int unsigned f = 0; f < nf; f++) begin
            if (f != 0) begin
              rec.push_back(p_sep);
              if (p_merge && $urandom_range(2) == 0) rec.push_back(p_sep);
            end
            flen = ($urandom_range(3) == 0) ? 0 : $urandom_range(4, 1);
            repeat (flen) rec.push_back(text_byte());
            // final field may carry separators in take mode
            if (p_take && f + 1 == nf && $urandom_range(1)) begin
              rec.push_back(p_sep);
              rec.push_back(text_byte());
            end
          end
          if (rec.size() == 0) rec.push_back(text_byte());
        end else begin
          // noise, dense in separators
          flen = $urandom_range(10, 1);
          repeat (flen) rec.push_back(($urandom_range(2) == 0) ? p_sep : text_byte());
        end
        foreach (rec[k]) send_byte(rec[k], k == rec.size() - 1, 1'b0, '0);
        sent += rec.size();
      end
    end

    settle();
    repeat (TAIL_GAP) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/dfs_pkg.sv
hdl/dfs_in_if.sv
hdl/dfs_out_if.sv
hdl/dfs_field_mem.sv
hdl/dfs_scanner.sv
hdl/delimited_field_splitter_unit.sv
test/tb.sv
